### hw/rtl/pinhole_point_projection_core_defines.svh
// Assertion macros for the pinhole projection core.
`ifndef PINHOLE_POINT_PROJECTION_CORE_DEFINES_SVH
`define PINHOLE_POINT_PROJECTION_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PPP_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PPP_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define PPP_ASSERT(lbl, clk, rstn, prop, msg)
`define PPP_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

### hw/rtl/ppp_pkg.sv
`default_nettype none
package ppp_pkg;
  localparam int NumW = 87;
  localparam int RemW = 54;
  localparam int QW   = 41;
  localparam int CamW = 55;
  localparam logic signed [CamW-1:0] MinDepth = 55'sd17180;

  typedef enum logic [2:0] {
    CFG_ROT0      = 3'd0,
    CFG_ROT1      = 3'd1,
    CFG_ROT2      = 3'd2,
    CFG_TRANS_XY  = 3'd3,
    CFG_TRANS_Z   = 3'd4,
    CFG_FOCAL     = 3'd5,
    CFG_PRINCIPAL = 3'd6,
    CFG_NONE      = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic            valid;
    logic            vis;
    logic [RemW-1:0] d;
    logic [31:0]     depth;
  } side_t;

  typedef struct packed {
    logic [NumW-1:0] n;
    logic [RemW-1:0] r;
    logic [QW-1:0]   q;
    logic            big;
    logic            neg;
  } lane_t;
endpackage
`default_nettype wire

### hw/rtl/pinhole_point_projection_core.sv
// An accepted request reaches its result through 4 front stages,
// 87 division cells and 1 output register.
// Throughput: one point per cycle unless the output stalls; each cell retires one
// quotient bit per lane. A stalled output freezes the whole chain.
// Reset: asynchronous active low; clears valid flags, loads identity rotation, zero rest.
`default_nettype none
`include "pinhole_point_projection_core_defines.svh"
module pinhole_point_projection_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [63:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [95:0] s_axis_tdata_i,   // point_x, point_y, point_z
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [95:0]      m_axis_tdata_o,   // image_x, image_y, cam_depth
  output logic [0:0]       m_axis_tuser_o    // visible
);
  import ppp_pkg::*;

  logic [62:0] rot0_q, rot1_q, rot2_q;
  logic [63:0] txy_q, focal_q, pp_q;
  logic [31:0] tz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot0_q  <= 63'd262144;
      rot1_q  <= 63'd262144 << 21;
      rot2_q  <= 63'd262144 << 42;
      txy_q   <= '0;
      tz_q    <= '0;
      focal_q <= '0;
      pp_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_ROT0:      rot0_q  <= cfg_wdata_i[62:0];
        CFG_ROT1:      rot1_q  <= cfg_wdata_i[62:0];
        CFG_ROT2:      rot2_q  <= cfg_wdata_i[62:0];
        CFG_TRANS_XY:  txy_q   <= cfg_wdata_i;
        CFG_TRANS_Z:   tz_q    <= cfg_wdata_i[31:0];
        CFG_FOCAL:     focal_q <= cfg_wdata_i;
        CFG_PRINCIPAL: pp_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_v_q;
  assign adv = !(out_v_q && !m_axis_tready_i);
  assign s_axis_tready_o = adv;

  side_t side [NumW+1];
  lane_t lx [NumW+1];
  lane_t ly [NumW+1];

  ppp_front u_front (
    .clk_i, .rst_ni, .adv_i(adv), .valid_i(s_axis_tvalid_i), .point_i(s_axis_tdata_i),
    .rot0_i(rot0_q), .rot1_i(rot1_q), .rot2_i(rot2_q), .trans_xy_i(txy_q),
    .trans_z_i(tz_q), .focal_i(focal_q),
    .side_o(side[0]), .lx_o(lx[0]), .ly_o(ly[0])
  );

  for (genvar g = 0; g < NumW; g++) begin : g_cell
    ppp_cell u_cell (
      .clk_i, .rst_ni, .adv_i(adv),
      .side_i(side[g]), .lx_i(lx[g]), .ly_i(ly[g]),
      .side_o(side[g+1]), .lx_o(lx[g+1]), .ly_o(ly[g+1])
    );
  end

  function automatic logic [31:0] finish(lane_t l, logic [31:0] p);
    logic signed [42:0] v;
    v = (l.neg ? -{2'b0, l.q} : {2'b0, l.q}) + {{11{p[31]}}, p};
    if (v[42:31] == 12'h000 || v[42:31] == 12'hfff) begin
      return v[31:0];
    end else if (v[42]) begin
      return 32'h8000_0000;
    end else begin
      return 32'h7fff_ffff;
    end
  endfunction

  logic [95:0] data_q;
  logic        vis_q;
  logic [31:0] ix_d, iy_d;
  assign ix_d = side[NumW].vis ? finish(lx[NumW], pp_q[31:0]) : 32'd0;
  assign iy_d = side[NumW].vis ? finish(ly[NumW], pp_q[63:32]) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= side[NumW].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      data_q <= {side[NumW].depth, iy_d, ix_d};
      vis_q  <= side[NumW].vis;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tuser_o  = vis_q;

  `PPP_ASSERT(a_hidden_zero, clk_i, rst_ni, (out_v_q && !vis_q) |-> (data_q[63:0] == 64'd0), "hidden point with nonzero pixel")
  `PPP_ASSERT(a_vis_depth, clk_i, rst_ni, (out_v_q && vis_q) |-> !data_q[95], "visible point with negative depth")
  `PPP_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, !adv, $stable(side[NumW].valid) && out_v_q, "chain moved during stall")
  `PPP_ASSERT(a_ready, clk_i, rst_ni, s_axis_tready_o == (!out_v_q || m_axis_tready_i), "ready mismatch")
endmodule
`default_nettype wire

### hw/rtl/ppp_cell.sv
`default_nettype none
module ppp_cell (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire ppp_pkg::side_t side_i,
  input  wire ppp_pkg::lane_t lx_i,
  input  wire ppp_pkg::lane_t ly_i,
  output ppp_pkg::side_t     side_o,
  output ppp_pkg::lane_t     lx_o,
  output ppp_pkg::lane_t     ly_o
);
  import ppp_pkg::*;

  function automatic lane_t step(lane_t l, logic [RemW-1:0] d);
    logic [RemW:0]  rr;
    logic [RemW:0]  diff;
    logic           ge;
    logic [QW-1:0]  qs;
    logic           nb;
    lane_t          o;
    rr   = {l.r, l.n[NumW-1]};
    diff = rr - {1'b0, d};
    ge   = rr >= {1'b0, d};
    qs   = {l.q[QW-2:0], ge};
    nb   = l.big | qs[QW-1];
    o.n   = {l.n[NumW-2:0], 1'b0};
    o.r   = ge ? diff[RemW-1:0] : rr[RemW-1:0];
    o.q   = nb ? {1'b1, {(QW-1){1'b0}}} : qs;
    o.big = nb;
    o.neg = l.neg;
    return o;
  endfunction

  logic  valid_q;
  side_t pay_q;
  lane_t lx_q, ly_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= side_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pay_q <= side_i;
      lx_q  <= step(lx_i, side_i.d);
      ly_q  <= step(ly_i, side_i.d);
    end
  end

  always_comb begin
    side_o       = pay_q;
    side_o.valid = valid_q;
  end
  assign lx_o = lx_q;
  assign ly_o = ly_q;
endmodule
`default_nettype wire

### hw/rtl/ppp_front.sv
`default_nettype none
module ppp_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          adv_i,
  input  wire logic          valid_i,
  input  wire logic [95:0]   point_i,
  input  wire logic [62:0]   rot0_i,
  input  wire logic [62:0]   rot1_i,
  input  wire logic [62:0]   rot2_i,
  input  wire logic [63:0]   trans_xy_i,
  input  wire logic [31:0]   trans_z_i,
  input  wire logic [63:0]   focal_i,
  output ppp_pkg::side_t     side_o,
  output ppp_pkg::lane_t     lx_o,
  output ppp_pkg::lane_t     ly_o
);
  import ppp_pkg::*;

  logic [3:0] v_q;
  logic signed [52:0] pr_q [9];
  logic signed [CamW-1:0] cx_q, cy_q, cz_q;
  logic [63:0] plo_x_q, plo_y_q;
  logic [53:0] phi_x_q, phi_y_q;
  logic        nx3_q, ny3_q, vis3_q;
  logic [RemW-1:0] d3_q;
  logic [31:0] dep3_q;
  side_t side_q;
  lane_t lx_q, ly_q;

  logic signed [20:0] cf [9];
  logic signed [31:0] pt [3];
  logic signed [52:0] pr_d [9];
  assign pt[0] = point_i[31:0];
  assign pt[1] = point_i[63:32];
  assign pt[2] = point_i[95:64];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cf[k]   = rot0_i[21*k +: 21];
      cf[3+k] = rot1_i[21*k +: 21];
      cf[6+k] = rot2_i[21*k +: 21];
    end
    for (int i = 0; i < 9; i++) begin
      pr_d[i] = cf[i] * pt[i%3];
    end
  end

  function automatic logic signed [CamW-1:0] axis(logic signed [52:0] a, logic signed [52:0] b,
                                                  logic signed [52:0] c, logic [31:0] t);
    logic signed [CamW-1:0] ts;
    ts = {{5{t[31]}}, t, 18'b0};
    return CamW'(a) + CamW'(b) + CamW'(c) + ts;
  endfunction

  logic signed [CamW-1:0] cx_d, cy_d, cz_d;
  assign cx_d = axis(pr_q[0], pr_q[1], pr_q[2], trans_xy_i[31:0]);
  assign cy_d = axis(pr_q[3], pr_q[4], pr_q[5], trans_xy_i[63:32]);
  assign cz_d = axis(pr_q[6], pr_q[7], pr_q[8], trans_z_i);

  logic [CamW-1:0] mx_full, my_full;
  logic [RemW-1:0] mx, my;
  logic signed [CamW:0]  dround;
  logic signed [37:0]    dsh;
  logic [31:0]           dep_d;
  logic                  vis_d;
  assign mx_full = cx_q[CamW-1] ? -cx_q : cx_q;
  assign my_full = cy_q[CamW-1] ? -cy_q : cy_q;
  assign mx = mx_full[RemW-1:0];
  assign my = my_full[RemW-1:0];
  assign vis_d = cz_q >= MinDepth;
  assign dround = {cz_q[CamW-1], cz_q} + 56'sd131072;
  assign dsh = 38'(dround >>> 18);
  always_comb begin
    if (dsh[37:31] == 7'h00 || dsh[37:31] == 7'h7f) begin
      dep_d = dsh[31:0];
    end else if (dsh[37]) begin
      dep_d = 32'h8000_0000;
    end else begin
      dep_d = 32'h7fff_ffff;
    end
  end

  function automatic logic [NumW-1:0] numer(logic [63:0] plo, logic [53:0] phi,
                                            logic [RemW-1:0] d);
    return {23'b0, plo} + {1'b0, phi, 32'b0} + {34'b0, d[RemW-1:1]};
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      pr_q    <= pr_d;
      cx_q    <= cx_d;
      cy_q    <= cy_d;
      cz_q    <= cz_d;
      plo_x_q <= mx[31:0] * focal_i[31:0];
      phi_x_q <= mx[53:32] * focal_i[31:0];
      plo_y_q <= my[31:0] * focal_i[63:32];
      phi_y_q <= my[53:32] * focal_i[63:32];
      nx3_q   <= cx_q[CamW-1];
      ny3_q   <= cy_q[CamW-1];
      vis3_q  <= vis_d;
      d3_q    <= vis_d ? cz_q[RemW-1:0] : RemW'(1);
      dep3_q  <= dep_d;
      side_q.vis   <= vis3_q;
      side_q.d     <= d3_q;
      side_q.depth <= dep3_q;
      side_q.valid <= 1'b0;
      lx_q <= '{n: numer(plo_x_q, phi_x_q, d3_q), r: '0, q: '0, big: 1'b0, neg: nx3_q};
      ly_q <= '{n: numer(plo_y_q, phi_y_q, d3_q), r: '0, q: '0, big: 1'b0, neg: ny3_q};
    end
  end

  always_comb begin
    side_o       = side_q;
    side_o.valid = v_q[3];
  end
  assign lx_o = lx_q;
  assign ly_o = ly_q;
endmodule
`default_nettype wire

### tb/sv/tb_pinhole_point_projection_core.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_pinhole_point_projection_core;
  import ppp_pkg::*;

  typedef struct {
    logic        vis;
    logic [31:0] img_x;
    logic [31:0] img_y;
    logic [31:0] depth;
  } proj_t;

  class projection_board;
    logic [62:0] rot_row[3];
    logic [63:0] trans_xy;
    logic [31:0] trans_z;
    logic [63:0] focal_xy;
    logic [63:0] principal_xy;
    proj_t       pending[$];
    int          errors;

    function new();
      rot_row[0]   = 63'd262144;
      rot_row[1]   = 63'd262144 << 21;
      rot_row[2]   = 63'd262144 << 42;
      trans_xy     = '0;
      trans_z      = '0;
      focal_xy     = '0;
      principal_xy = '0;
      errors       = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [63:0] v);
      case (idx)
        CFG_ROT0:      rot_row[0] = v[62:0];
        CFG_ROT1:      rot_row[1] = v[62:0];
        CFG_ROT2:      rot_row[2] = v[62:0];
        CFG_TRANS_XY:  trans_xy = v;
        CFG_TRANS_Z:   trans_z = v[31:0];
        CFG_FOCAL:     focal_xy = v;
        CFG_PRINCIPAL: principal_xy = v;
        default: ;
      endcase
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint cam_axis(logic [62:0] row, longint x, longint y, longint z,
                              longint t);
      longint c0, c1, c2;
      c0 = $signed(row[20:0]);
      c1 = $signed(row[41:21]);
      c2 = $signed(row[62:42]);
      return c0 * x + c1 * y + c2 * z + t * 64'sd262144;
    endfunction

    function longint pixel(longint c, longint cz, logic [31:0] f, longint p);
      logic [127:0] num, quo;
      longint mag, q;
      mag = (c < 0) ? -c : c;
      num = 128'(mag) * 128'(f) + 128'(cz >>> 1);
      quo = num / 128'(cz);
      if (quo > (128'd1 << 40)) quo = 128'd1 << 40;
      q = longint'(quo[63:0]);
      if (c < 0) q = -q;
      return sat32(q + p);
    endfunction

    function void note_point(logic [95:0] pt);
      longint px, py, pz, cx, cy, cz, d;
      proj_t r;
      px = $signed(pt[31:0]);
      py = $signed(pt[63:32]);
      pz = $signed(pt[95:64]);
      cx = cam_axis(rot_row[0], px, py, pz, longint'($signed(trans_xy[31:0])));
      cy = cam_axis(rot_row[1], px, py, pz, longint'($signed(trans_xy[63:32])));
      cz = cam_axis(rot_row[2], px, py, pz, longint'($signed(trans_z)));
      d = sat32((cz + 64'sd131072) >>> 18);
      r.vis   = (cz >= 64'sd17180);
      r.depth = d[31:0];
      r.img_x = '0;
      r.img_y = '0;
      if (r.vis) begin
        r.img_x = 32'(pixel(cx, cz, focal_xy[31:0], longint'($signed(principal_xy[31:0]))));
        r.img_y = 32'(pixel(cy, cz, focal_xy[63:32],
                            longint'($signed(principal_xy[63:32]))));
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic vis, logic [95:0] data);
      proj_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result vis=%0b data=%h", $time, vis, data);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (vis !== e.vis) begin
        $display("%0t: visible exp %0b got %0b", $time, e.vis, vis);
        errors++;
      end
      if (data[31:0] !== e.img_x) begin
        $display("%0t: image_x exp %h got %h", $time, e.img_x, data[31:0]);
        errors++;
      end
      if (data[63:32] !== e.img_y) begin
        $display("%0t: image_y exp %h got %h", $time, e.img_y, data[63:32]);
        errors++;
      end
      if (data[95:64] !== e.depth) begin
        $display("%0t: cam_depth exp %h got %h", $time, e.depth, data[95:64]);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [63:0] cfg_wdata_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [95:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [95:0] m_axis_tdata_o;
  logic [0:0]  m_axis_tuser_o;

  projection_board board;
  bit              no_idle;
  int              quiet_cycles;

  pinhole_point_projection_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_wdata_i(cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i), .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o), .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o), .m_axis_tuser_o(m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [63:0] v);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    board.set_reg(idx, v);
    @(posedge clk_i);
  endtask

  task automatic configure(int mode);
    logic [63:0] v[7];
    logic [20:0] a, b;
    case (mode)
      0: begin
        v[0] = 64'({21'd0, 21'd0, 21'd262144 + 21'($urandom_range(0, 4000)) - 21'd2000});
        v[1] = 64'({21'd0, 21'd262144, 21'($urandom_range(0, 4000)) - 21'd2000}) << 0;
        v[1] = {1'b0, 21'd0, 21'd262144, 21'($urandom_range(0, 4000)) - 21'd2000};
        v[2] = {1'b0, 21'd262144, 21'($urandom_range(0, 4000)) - 21'd2000, 21'd0};
        v[3] = {32'($urandom_range(0, 1 << 22)) - 32'd2097152,
                32'($urandom_range(0, 1 << 22)) - 32'd2097152};
        v[4] = 64'($urandom_range(0, 1 << 22));
        v[5] = {32'($urandom_range(0, 32'h4000000)), 32'($urandom_range(0, 32'h4000000))};
        v[6] = {$urandom, $urandom};
      end
      1: for (int i = 0; i < 7; i++) v[i] = {$urandom, $urandom};
      2: for (int i = 0; i < 7; i++) v[i] = '1;
      default: begin
        a = 21'h0FFFFF;
        b = 21'h100000;
        v[0] = {1'b0, a, a, a};
        v[1] = {1'b0, b, b, b};
        v[2] = {1'b0, a, b, a};
        v[3] = {32'h80000000, 32'h7FFFFFFF};
        v[4] = 64'h7FFFFFFF;
        v[5] = {32'hFFFFFFFF, 32'h00000001};
        v[6] = {32'h7FFFFFFF, 32'h80000000};
      end
    endcase
    for (int i = 0; i < 7; i++) write_reg(cfg_idx_e'(i), v[i]);
    write_reg(CFG_NONE, {$urandom, $urandom});
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_point(logic [95:0] pt);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= pt;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    board.note_point(pt);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  function automatic logic [31:0] near_val();
    return 32'($urandom_range(0, 1 << 21)) - 32'd1048576;
  endfunction

  task automatic run_directed();
    logic [31:0] mx, mn;
    mx = 32'h7FFFFFFF;
    mn = 32'h80000000;
    send_point({32'd0, 32'd0, 32'd0});
    send_point({mx, mx, mx});
    send_point({mn, mn, mn});
    send_point({32'd1, 32'd1, 32'd1});
    send_point({32'd1, 32'd0, 32'd0});
    send_point({32'd1, mn, mx});
    send_point({32'd1, mx, mn});
    send_point({32'hFFFFFFFF, 32'd0, 32'd0});
    send_point({mx, 32'hFFFFFFFF, 32'd1});
    send_point({32'd2, 32'd1, 32'hFFFFFFFF});
    send_point({32'd65536, 32'hFFFF0000, 32'd65536});
    send_point({32'd1, mx, mx});
  endtask

  initial begin
    board           = new();
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_NONE;
    cfg_wdata_i     = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    quiet_cycles    = 0;
    no_idle         = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    drain();
    write_reg(CFG_FOCAL, 64'hFFFFFFFF_FFFFFFFF);
    write_reg(CFG_PRINCIPAL, {32'h80000000, 32'h7FFFFFFF});
    write_reg(CFG_NONE, '1);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    run_directed();

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      configure(ph % 4);
      @(posedge clk_i);
      no_idle = (ph % 3 == 1);
      for (int n = 0; n < 200; n++) begin
        if ($urandom_range(0, 1)) begin
          send_point({32'($urandom_range(1, 1 << 21)), near_val(), near_val()});
        end else begin
          send_point({$urandom, $urandom, $urandom});
        end
      end
    end
    drain();

    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
      board.check_result(m_axis_tuser_o[0], m_axis_tdata_o);
    end
  end
endmodule
`default_nettype wire
